### rtl/core/g2r_pkg.sv
// Shared types, mode codes and character constants for the glob-to-regex translator.
package g2r_pkg;

  typedef logic [7:0] char_t;
  typedef logic [1:0] mode_t;
  typedef logic [1:0] count_t;

  // Brace depth limit used as the default of the top level parameter.
  localparam int unsigned MaxBraceDepthDef = 255;

  // Translator modes; the unused code is treated as normal mode.
  localparam mode_t MODE_NORMAL  = 2'd0;
  localparam mode_t MODE_BRACKET = 2'd1;
  localparam mode_t MODE_ESCAPE  = 2'd2;

  // Characters with a special role in either syntax.
  localparam char_t CH_CARET  = 8'h5E;  // ^
  localparam char_t CH_DOLLAR = 8'h24;  // $
  localparam char_t CH_LPAREN = 8'h28;  // (
  localparam char_t CH_RPAREN = 8'h29;  // )
  localparam char_t CH_DOT    = 8'h2E;  // .
  localparam char_t CH_PLUS   = 8'h2B;  // +
  localparam char_t CH_PIPE   = 8'h7C;  // |
  localparam char_t CH_LBRACE = 8'h7B;  // {
  localparam char_t CH_RBRACE = 8'h7D;  // }
  localparam char_t CH_COMMA  = 8'h2C;  // ,
  localparam char_t CH_LBRACK = 8'h5B;  // [
  localparam char_t CH_RBRACK = 8'h5D;  // ]
  localparam char_t CH_BANG   = 8'h21;  // !
  localparam char_t CH_STAR   = 8'h2A;  // *
  localparam char_t CH_QUEST  = 8'h3F;  // ?
  localparam char_t CH_BSLASH = 8'h5C;  // backslash

endpackage

### rtl/core/g2r_if.sv
// Valid/ready channel interfaces for pattern characters and regex characters.
interface g2r_in_if;
  import g2r_pkg::*;

  logic  valid;
  logic  ready;
  char_t in_char;
  logic  end_of_pattern;

  modport source (output valid, output in_char, output end_of_pattern, input ready);
  modport sink   (input valid, input in_char, input end_of_pattern, output ready);
endinterface

interface g2r_out_if;
  import g2r_pkg::*;

  logic  valid;
  logic  ready;
  char_t out_char;
  logic  last_of_run;
  logic  pattern_done;

  modport source (output valid, output out_char, output last_of_run, output pattern_done,
                  input ready);
  modport sink   (input valid, input out_char, input last_of_run, input pattern_done,
                  output ready);
endinterface

### rtl/core/glob_to_regex_translator_top.sv
// Glob-to-regex translator: one pattern character in, zero to two regex characters out.
// Each accepted pattern character is translated in the cycle of its transfer and its
// results (zero, one or two characters) are loaded into a two-entry output register;
// they are offered from the next cycle on and leave one per cycle while the sink is
// ready. A new character is taken when that register is empty or its last character
// leaves in the same cycle, so a character that yields two results holds off the next
// one until the first of them has left. A character that yields nothing (a backslash
// that opens an escape) leaves the register empty. The last character of a pattern
// returns the mode, brace depth and bracket state to reset.
module glob_to_regex_translator_top #(
  parameter int unsigned MAX_BRACE_DEPTH = g2r_pkg::MaxBraceDepthDef
) (
  input  logic     clk,
  input  logic     rst_n,
  g2r_in_if.sink   in_ch,
  g2r_out_if.source out_ch
);
  import g2r_pkg::*;

  localparam int unsigned DepthW = $clog2(MAX_BRACE_DEPTH + 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_BRACE_DEPTH);

  // Translation state.
  mode_t             mode_r,  mode_nxt;
  logic [DepthW-1:0] depth_r, depth_nxt;
  logic              has_r,   has_nxt;

  // Output register: ch0 is sent first when two characters are held.
  char_t  ch0_r, ch0_nxt;
  char_t  ch1_r, ch1_nxt;
  count_t cnt_r, cnt_nxt;
  logic   eop_r;

  logic in_xfer;
  logic out_xfer;
  char_t c;

  assign in_ch.ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_ch.valid && out_ch.ready;

  // Translate one character and work out the following state.
  always_comb begin
    c         = in_ch.in_char;
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    has_nxt   = has_r;
    ch0_nxt   = CH_BSLASH;
    ch1_nxt   = c;
    cnt_nxt   = 2'd1;
    case (mode_r)
      MODE_BRACKET: begin
        if ((c == CH_RBRACK) && has_r) begin
          mode_nxt = MODE_NORMAL;
        end else if ((c == CH_BANG) && !has_r) begin
          ch1_nxt = CH_CARET;
        end
        has_nxt = 1'b1;
      end
      MODE_ESCAPE: begin
        mode_nxt = MODE_NORMAL;
        // The backslash is kept except before a comma.
        if (c != CH_COMMA) begin
          cnt_nxt = 2'd2;
        end
      end
      default: begin
        mode_nxt = MODE_NORMAL;
        if (c inside {CH_CARET, CH_DOLLAR, CH_LPAREN, CH_RPAREN, CH_DOT, CH_PLUS,
                      CH_PIPE}) begin
          cnt_nxt = 2'd2;
        end else begin
          case (c)
            CH_LBRACE: begin
              if (depth_r < DepthMax) begin
                depth_nxt = depth_r + DepthW'(1);
              end
              ch1_nxt = CH_LPAREN;
            end
            CH_COMMA: begin
              if (depth_r != '0) begin
                ch1_nxt = CH_PIPE;
              end
            end
            CH_RBRACE: begin
              if (depth_r != '0) begin
                depth_nxt = depth_r - DepthW'(1);
                ch1_nxt   = CH_RPAREN;
              end
            end
            CH_LBRACK: begin
              mode_nxt = MODE_BRACKET;
              has_nxt  = 1'b0;
            end
            CH_STAR: begin
              ch0_nxt = CH_DOT;
              cnt_nxt = 2'd2;
            end
            CH_QUEST: begin
              ch1_nxt = CH_DOT;
            end
            CH_BSLASH: begin
              mode_nxt = MODE_ESCAPE;
              cnt_nxt  = 2'd0;
            end
            default: begin
            end
          endcase
        end
      end
    endcase

    // The end of a pattern flushes a pending backslash and clears all state.
    if (in_ch.end_of_pattern) begin
      if (mode_nxt == MODE_ESCAPE) begin
        ch1_nxt = CH_BSLASH;
        cnt_nxt = 2'd1;
      end
      mode_nxt  = MODE_NORMAL;
      depth_nxt = '0;
      has_nxt   = 1'b0;
    end
  end

  // State registers advance on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      depth_r <= '0;
      has_r   <= 1'b0;
    end else if (in_xfer) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      has_r   <= has_nxt;
    end
  end

  // Output register fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (in_xfer) begin
      cnt_r <= cnt_nxt;
    end else if (out_xfer) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ch0_r <= ch0_nxt;
      ch1_r <= ch1_nxt;
      eop_r <= in_ch.end_of_pattern;
    end
  end

  // The last held character always sits in ch1.
  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.out_char     = (cnt_r == 2'd2) ? ch0_r : ch1_r;
  assign out_ch.last_of_run  = (cnt_r == 2'd1);
  assign out_ch.pattern_done = (cnt_r == 2'd1) && eop_r;

endmodule

### rtl/core/g2r_checker.sv
// Port-level assertions for the glob-to-regex translator and their bind.
module g2r_sva_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       last_of_run,
  input logic       pattern_done
);

  // A result held back by the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char))
    else $error("result dropped or changed while stalled");

  // The end of a pattern is only marked on the last result of its character.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pattern_done |-> last_of_run)
    else $error("pattern end marked on a result that is not last of its run");

  // The block only refuses input while it still has results to deliver.
  a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input refused with no result pending");

  // Reset leaves no result on offer.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind glob_to_regex_translator_top g2r_sva_checker u_g2r_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_char     (out_ch.out_char),
  .last_of_run  (out_ch.last_of_run),
  .pattern_done (out_ch.pattern_done)
);
